// ===== sv/orbcr_pkg.sv =====
// shared constants, codes and pointer helper for the overwrite ring buffer
package orbcr_pkg;

	localparam int DEPTH      = 256;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CAP_W      = $clog2(DEPTH + 1);

	// fixed field widths of the stream words and the capacity register
	localparam int CFG_W      = 9;
	localparam int IDX_W      = 9;
	localparam int SLOT_W     = 8;
	localparam int WDATA_W    = 32;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// pointer plus one, wrapping at the active capacity
	function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] ptr,
			input logic [CAP_W-1:0] cap);
		logic [CAP_W:0] n;
		n = (CAP_W + 1)'(ptr) + 1'b1;
		advance = (n >= (CAP_W + 1)'(cap)) ? '0 : n[ADDR_W-1:0];
	endfunction

endpackage

// ===== sv/overwrite_ring_buffer_cursor_read.sv =====
// overwrite-oldest ring buffer with non-consuming cursor reads
//
// one stream in (s_*), one stream out (m_*), one capacity register (cfg_*).
// each input word is a write (s_tuser = 0) or a cursor read (s_tuser = 1).
// a write stores its data at the next-write slot; once the ring is full the
// oldest item is overwritten. a write gives no output word.
// a read asks for a slot (-1 = oldest) and gives exactly one output word:
// m_tuser (found) and the data, served slot and following cursor.
// one word is taken per cycle while s_tready is high; the slot memory is a
// single-port ram with a registered read, so a read's result is held in
// the read stage beside the ram read data and then moves into the output
// register, from which it leaves. a write is visible to a read accepted in
// the very next cycle since the ram is written at the write's own edge.
// if the receiver stalls, one result waits in the output register and one
// more in the read stage; then s_tready drops until the output drains.
// reset clears both pointers and sets capacity to the full depth; slot
// contents are undefined until written. writing capacity (clamped to
// 2..depth) clears both pointers; do it only while the block is idle.
module overwrite_ring_buffer_cursor_read
	import orbcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// capacity register
	input  logic        cfg_we,
	input  logic [8:0]  cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // write_data[31:0], desired_index[40:32], zero pad
	input  logic        s_tuser,  // opcode
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // read_data[31:0], served_index[39:32], next_index[47:40]
	output logic        m_tuser   // found
);

	// pointers and capacity
	logic [CAP_W-1:0]  capacity_q;
	logic [ADDR_W-1:0] oldest_q;
	logic [ADDR_W-1:0] write_q;

	// read stage, lines up with the ram read data
	logic              valid_s1;
	logic              found_s1;
	logic [ADDR_W-1:0] served_s1;
	logic [ADDR_W-1:0] next_s1;

	// output register
	logic              out_valid_q;
	logic              out_found_q;
	logic [WDATA_W-1:0] out_data_q;
	logic [SLOT_W-1:0] out_served_q;
	logic [SLOT_W-1:0] out_next_q;

	logic              in_fire;
	logic              adv_s1;
	logic              is_write;
	logic              is_read;
	logic [WDATA_W-1:0] wdata_in;
	logic [IDX_W-1:0]  desired;
	logic              desired_neg;
	logic [ADDR_W-1:0] desired_slot;
	logic              ring_empty;
	logic              caught_up;
	logic              outside;
	logic              found_c;
	logic [ADDR_W-1:0] served_c;
	logic [ADDR_W-1:0] write_next;
	logic [CAP_W-1:0]  cap_clamped;
	logic              ram_en;
	logic [ADDR_W-1:0] ram_addr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic [DATA_WIDTH-1:0] ram_rdata;

	assign wdata_in     = s_tdata[WDATA_W-1:0];
	assign desired      = s_tdata[WDATA_W +: IDX_W];
	assign desired_neg  = desired[IDX_W-1];
	assign desired_slot = ADDR_W'(desired[IDX_W-2:0]);

	// read stage moves on when the output register is free or being drained
	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign in_fire  = s_tvalid && s_tready;
	assign is_write = in_fire && (s_tuser == OP_WRITE);
	assign is_read  = in_fire && (s_tuser == OP_READ);

	// read decision: found unless empty or caught up; outside slots serve the oldest
	always_comb begin
		ring_empty = (oldest_q == write_q);
		caught_up  = !desired_neg && (32'(desired[IDX_W-2:0]) == 32'(write_q));
		found_c    = !(ring_empty || caught_up);
		if (desired_neg || (32'(desired[IDX_W-2:0]) >= 32'(capacity_q))) begin
			outside = 1'b1;
		end else if (oldest_q < write_q) begin
			// window without wrap
			outside = (desired_slot < oldest_q) || (desired_slot > write_q);
		end else begin
			// window wraps past the end of the ring
			outside = (desired_slot < oldest_q) && (desired_slot > write_q);
		end
		served_c = outside ? oldest_q : desired_slot;
	end

	assign write_next = advance(write_q, capacity_q);

	// capacity clamp to 2..depth
	always_comb begin
		priority if (32'(cfg_data) < 2) begin
			cap_clamped = CAP_W'(2);
		end else if (32'(cfg_data) > DEPTH) begin
			cap_clamped = CAP_W'(DEPTH);
		end else begin
			cap_clamped = CAP_W'(cfg_data);
		end
	end

	// slot memory: writes store at the write pointer, reads fetch the served slot
	assign ram_en    = is_write || is_read;
	assign ram_addr  = is_write ? write_q : served_c;
	assign ram_wdata = DATA_WIDTH'(wdata_in);

	orbcr_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.en    (ram_en),
		.we    (is_write),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// pointers and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_W'(DEPTH);
			oldest_q   <= '0;
			write_q    <= '0;
		end else if (cfg_we) begin
			capacity_q <= cap_clamped;
			oldest_q   <= '0;
			write_q    <= '0;
		end else if (is_write) begin
			write_q <= write_next;
			// ring full: drop the oldest item
			if (write_next == oldest_q) begin
				oldest_q <= advance(oldest_q, capacity_q);
			end
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (is_read) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (is_read) begin
			found_s1  <= found_c;
			served_s1 <= served_c;
			next_s1   <= advance(served_c, capacity_q);
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload, zeros when nothing was found
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_found_q  <= found_s1;
			out_data_q   <= found_s1 ? WDATA_W'(ram_rdata) : '0;
			out_served_q <= found_s1 ? SLOT_W'(served_s1) : '0;
			out_next_q   <= found_s1 ? SLOT_W'(next_s1) : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = {out_next_q, out_served_q, out_data_q};

endmodule

// ===== sv/orbcr_ram.sv =====
// generic single-port ram with registered read
module orbcr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic                             we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                 wdata,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
